// ----- sv/pka_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the pad key auto-repeat block.
// Depends on nothing; every module of the block imports it.
package pka_pkg;

    // Time arithmetic width and key count
    localparam int TIME_BITS = 32;
    localparam int NKEYS     = 16;
    localparam int KEY_BITS  = 4;
    localparam int NBUTTONS  = 14;

    // Fixed key positions
    localparam logic [KEY_BITS-1:0] KEY_UP    = KEY_BITS'(10);
    localparam logic [KEY_BITS-1:0] KEY_DOWN  = KEY_BITS'(11);
    localparam logic [KEY_BITS-1:0] KEY_LEFT  = KEY_BITS'(12);
    localparam logic [KEY_BITS-1:0] KEY_RIGHT = KEY_BITS'(13);
    localparam logic [KEY_BITS-1:0] KEY_LTRIG = KEY_BITS'(14);
    localparam logic [KEY_BITS-1:0] KEY_RTRIG = KEY_BITS'(15);
    localparam logic [KEY_BITS-1:0] KEY_LAST  = KEY_BITS'(NKEYS - 1);

    // Request codes
    localparam logic REQ_POLL  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Register map (index = byte address / 4)
    localparam int ADDR_BITS = 5;
    localparam logic [2:0] REG_ENABLE    = 3'd0;
    localparam logic [2:0] REG_TRIG_TH   = 3'd1;
    localparam logic [2:0] REG_DIR_TH    = 3'd2;
    localparam logic [2:0] REG_FIRST_DLY = 3'd3;
    localparam logic [2:0] REG_REPEAT    = 3'd4;

    // Register reset values
    localparam logic        RST_ENABLE    = 1'b1;
    localparam logic [14:0] RST_TRIG_TH   = 15'd6554;
    localparam logic [14:0] RST_DIR_TH    = 15'd22938;
    localparam logic [15:0] RST_FIRST_DLY = 16'd500;
    localparam logic [15:0] RST_REPEAT    = 16'd100;

    typedef struct packed {
        logic        enable;
        logic [14:0] trig_th;
        logic [14:0] dir_th;
        logic [15:0] first_dly;
        logic [15:0] repeat_ivl;
    } cfg_t;

    // One classified poll, handed from the front end to the key scanner
    typedef struct packed {
        logic [TIME_BITS-1:0] now;
        logic [NKEYS-1:0]     levels;
        logic                 repeat_ok;
    } entry_t;

    // One key event
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                pressed;
        logic                is_repeat;
    } event_t;

endpackage

// ----- sv/pka_regs.sv -----
`timescale 1ns / 1ps
// APB-style configuration registers of the pad key auto-repeat block.
// Depends on pka_pkg.
module pka_regs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [pka_pkg::ADDR_BITS-1:0]   paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output pka_pkg::cfg_t                   cfg
);
    import pka_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    // Register write decode; unknown indexes are dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_ENABLE:    cfg_next.enable     = pwdata[0];
                REG_TRIG_TH:   cfg_next.trig_th    = pwdata[14:0];
                REG_DIR_TH:    cfg_next.dir_th     = pwdata[14:0];
                REG_FIRST_DLY: cfg_next.first_dly  = pwdata[15:0];
                REG_REPEAT:    cfg_next.repeat_ivl = pwdata[15:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable     <= RST_ENABLE;
            cfg_reg.trig_th    <= RST_TRIG_TH;
            cfg_reg.dir_th     <= RST_DIR_TH;
            cfg_reg.first_dly  <= RST_FIRST_DLY;
            cfg_reg.repeat_ivl <= RST_REPEAT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (reg_idx)
            REG_ENABLE:    prdata = {31'd0, cfg_reg.enable};
            REG_TRIG_TH:   prdata = {17'd0, cfg_reg.trig_th};
            REG_DIR_TH:    prdata = {17'd0, cfg_reg.dir_th};
            REG_FIRST_DLY: prdata = {16'd0, cfg_reg.first_dly};
            REG_REPEAT:    prdata = {16'd0, cfg_reg.repeat_ivl};
            default:       prdata = 32'd0;
        endcase
    end

endmodule

// ----- sv/pka_front.sv -----
`timescale 1ns / 1ps
// Front end: turns one poll or clear request into 16 key levels.
// Depends on pka_pkg.
module pka_front (
    input  pka_pkg::cfg_t   cfg,
    input  logic            req_type,
    input  logic [31:0]     now_ms,
    input  logic [13:0]     button_bits,
    input  logic [15:0]     stick_x,
    input  logic [15:0]     stick_y,
    input  logic [15:0]     left_trigger_level,
    input  logic [15:0]     right_trigger_level,
    input  logic            menu_active,
    output pka_pkg::entry_t entry
);
    import pka_pkg::*;

    logic signed [16:0] sx;
    logic signed [16:0] sy;
    logic signed [16:0] lt;
    logic signed [16:0] rt;
    logic signed [16:0] trig_th;
    logic signed [16:0] dir_th;
    logic signed [16:0] dir_th_neg;
    logic [NKEYS-1:0]   levels;

    // Sign-extend samples, zero-extend thresholds into a common signed width
    assign sx         = signed'({stick_x[15], stick_x});
    assign sy         = signed'({stick_y[15], stick_y});
    assign lt         = signed'({left_trigger_level[15], left_trigger_level});
    assign rt         = signed'({right_trigger_level[15], right_trigger_level});
    assign trig_th    = signed'({2'b00, cfg.trig_th});
    assign dir_th     = signed'({2'b00, cfg.dir_th});
    assign dir_th_neg = -dir_th;

    // Key levels; a clear or a disabled block reads every key as released
    always_comb
    begin
        levels = '0;
        if (req_type == REQ_POLL && cfg.enable)
        begin
            levels[NBUTTONS-1:0] = button_bits;
            levels[KEY_LTRIG]    = (lt >= trig_th);
            levels[KEY_RTRIG]    = (rt >= trig_th);
            if (menu_active)
            begin
                levels[KEY_UP]    = levels[KEY_UP]    || (sy <= dir_th_neg);
                levels[KEY_DOWN]  = levels[KEY_DOWN]  || (sy >= dir_th);
                levels[KEY_LEFT]  = levels[KEY_LEFT]  || (sx <= dir_th_neg);
                levels[KEY_RIGHT] = levels[KEY_RIGHT] || (sx >= dir_th);
            end
        end
    end

    assign entry.now       = TIME_BITS'(now_ms);
    assign entry.levels    = levels;
    assign entry.repeat_ok = menu_active && (req_type == REQ_POLL);

endmodule

// ----- sv/pka_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of classified requests between front end and key scanner.
// Depends on pka_pkg.
module pka_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  pka_pkg::entry_t wr_data,
    output logic            full,
    input  logic            rd,
    output logic            vld,
    output pka_pkg::entry_t rd_data
);
    import pka_pkg::*;

    entry_t     mem [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_wr;
    logic       do_rd;

    assign full    = (count_reg == 2'd2);
    assign vld     = (count_reg != 2'd0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && vld;
    assign rd_data = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_wr ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_rd ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 2'd1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

endmodule

// ----- sv/pka_back.sv -----
`timescale 1ns / 1ps
// Back end: scans the 16 keys of the head request one per cycle unless an event meets a
// full result register; keeps held flags, repeat deadlines and results. Depends on pka_pkg.
module pka_back (
    input  logic            clk,
    input  logic            rst_n,
    input  pka_pkg::cfg_t   cfg,
    input  logic            q_vld,
    input  pka_pkg::entry_t q_entry,
    output logic            q_pop,
    input  logic            pop,
    output logic            empty,
    output logic [pka_pkg::KEY_BITS-1:0] key_index,
    output logic            pressed,
    output logic            is_repeat,
    output logic            last
);
    import pka_pkg::*;

    // Scan state
    logic [KEY_BITS-1:0]  idx_reg;
    logic [KEY_BITS-1:0]  idx_next;
    logic                 flush_reg;
    logic                 flush_next;
    logic                 pend_vld_reg;
    logic                 pend_vld_next;
    event_t               pend_reg;
    event_t               pend_next;
    logic [NKEYS-1:0]     held_reg;
    logic [NKEYS-1:0]     held_next;
    logic [TIME_BITS-1:0] deadline_reg [NKEYS];

    // Result register
    logic                 out_vld_reg;
    logic                 out_vld_next;
    event_t               out_reg;
    logic                 out_last_reg;

    // Per-key evaluation
    logic                 level;
    logic                 held;
    logic [TIME_BITS-1:0] diff;
    logic                 reached;
    logic                 chg;
    logic                 rep;
    logic                 ev;
    logic                 out_space;
    logic                 scan;
    logic                 step;
    logic                 dl_wr;
    logic [TIME_BITS-1:0] dl_wdata;
    logic                 out_load;
    event_t               out_data;
    logic                 out_data_last;

    assign out_space = !out_vld_reg || pop;
    assign level     = q_entry.levels[idx_reg];
    assign held      = held_reg[idx_reg];
    assign diff      = q_entry.now - deadline_reg[idx_reg];
    assign reached   = !diff[TIME_BITS-1];
    assign chg       = (level != held);
    assign rep       = !chg && level && q_entry.repeat_ok && reached;
    assign ev        = chg || rep;
    assign scan      = q_vld && !flush_reg;
    // A new event displaces the pending one, which then needs a free result slot
    assign step      = scan && !(ev && pend_vld_reg && !out_space);
    assign dl_wr     = step && ev;
    assign dl_wdata  = q_entry.now + (chg ? TIME_BITS'(cfg.first_dly)
                                          : TIME_BITS'(cfg.repeat_ivl));

    // Scan sequencing; the last event of a request is held back until the
    // closing cycle so that it can be marked
    always_comb
    begin
        idx_next      = idx_reg;
        flush_next    = flush_reg;
        pend_vld_next = pend_vld_reg;
        pend_next     = pend_reg;
        held_next     = held_reg;
        q_pop         = 1'b0;
        out_load      = 1'b0;
        out_data      = pend_reg;
        out_data_last = 1'b0;
        if (step)
        begin
            if (chg)
                held_next[idx_reg] = level;
            if (ev)
            begin
                out_load            = pend_vld_reg;
                pend_vld_next       = 1'b1;
                pend_next.key       = idx_reg;
                pend_next.pressed   = level;
                pend_next.is_repeat = rep;
            end
            if (idx_reg == KEY_LAST)
                flush_next = 1'b1;
            else
                idx_next = idx_reg + KEY_BITS'(1);
        end
        else if (q_vld && flush_reg && (!pend_vld_reg || out_space))
        begin
            out_load      = pend_vld_reg;
            out_data_last = 1'b1;
            pend_vld_next = 1'b0;
            flush_next    = 1'b0;
            idx_next      = '0;
            q_pop         = 1'b1;
        end
    end

    assign out_vld_next = out_load ? 1'b1 : (pop ? 1'b0 : out_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            flush_reg    <= 1'b0;
            pend_vld_reg <= 1'b0;
            held_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            flush_reg    <= flush_next;
            pend_vld_reg <= pend_vld_next;
            held_reg     <= held_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Payload registers: pending event, result, deadlines
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (out_load)
        begin
            out_reg      <= out_data;
            out_last_reg <= out_data_last;
        end
        if (dl_wr)
            deadline_reg[idx_reg] <= dl_wdata;
    end

    assign empty     = !out_vld_reg;
    assign key_index = out_reg.key;
    assign pressed   = out_reg.pressed;
    assign is_repeat = out_reg.is_repeat;
    assign last      = out_last_reg;

    // Idle scanner holds no stale position or pending event
    a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
        !q_vld |-> (idx_reg == '0 && !flush_reg && !pend_vld_reg))
        else $error("scanner not clean while idle");

    // Closing cycle only follows the last key
    a_flush_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        flush_reg |-> (idx_reg == KEY_LAST))
        else $error("closing cycle away from last key");

    // Retiring a request restarts the scan cleanly
    a_pop_restart: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (idx_reg == '0 && !flush_reg && !pend_vld_reg))
        else $error("scan not restarted after retire");

    // A marked final event only comes from the closing cycle
    a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_data_last) |-> (flush_reg && q_pop))
        else $error("final event marked outside closing cycle");

endmodule

// ----- sv/pad_key_auto_repeat.sv -----
`timescale 1ns / 1ps
// Pad key auto-repeat: one request in, up to 16 key events out.
// Requests are scanned one at a time: a serial scan of the 16 keys through the single
// deadline read port, then a closing step that marks the last event. A two-entry queue
// accepts further requests while one is being scanned.
// Reset: all keys released, registers at their defaults, no clearing pass.
module pad_key_auto_repeat (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [pka_pkg::ADDR_BITS-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Request side
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [31:0] now_ms,
    input  logic [13:0] button_bits,
    input  logic [15:0] stick_x,
    input  logic [15:0] stick_y,
    input  logic [15:0] left_trigger_level,
    input  logic [15:0] right_trigger_level,
    input  logic        menu_active,
    // Event side
    output logic        empty,
    input  logic        pop,
    output logic [pka_pkg::KEY_BITS-1:0] key_index,
    output logic        pressed,
    output logic        is_repeat,
    output logic        last
);
    import pka_pkg::*;

    cfg_t   cfg;
    entry_t fe_entry;
    entry_t q_entry;
    logic   q_vld;
    logic   q_pop;

    pka_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pka_front u_front (
        .cfg                 (cfg),
        .req_type            (req_type),
        .now_ms              (now_ms),
        .button_bits         (button_bits),
        .stick_x             (stick_x),
        .stick_y             (stick_y),
        .left_trigger_level  (left_trigger_level),
        .right_trigger_level (right_trigger_level),
        .menu_active         (menu_active),
        .entry               (fe_entry)
    );

    pka_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (push),
        .wr_data (fe_entry),
        .full    (full),
        .rd      (q_pop),
        .vld     (q_vld),
        .rd_data (q_entry)
    );

    pka_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_vld     (q_vld),
        .q_entry   (q_entry),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .key_index (key_index),
        .pressed   (pressed),
        .is_repeat (is_repeat),
        .last      (last)
    );

endmodule

// ----- tb/sv/pad_key_auto_repeat_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for pad_key_auto_repeat: directed polls and clears, then random
// frame-like poll streams under varied register settings and handshake pressure.
// Depends on pka_pkg and the pad_key_auto_repeat RTL only.
module pad_key_auto_repeat_tb;
    import pka_pkg::*;

    localparam int DRAIN_CYCLES = 40;    // covers two queued requests with no events
    localparam int QUIET_LIMIT  = 4000;  // cycles with no transfer before giving up
    localparam int PHASE_ITEMS  = 50;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic        req;
        logic [31:0] now;
        logic [13:0] buttons;
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] lt;
        logic [15:0] rt;
        logic        menu;
    } pad_req_t;

    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic                pressed;
        logic                rep;
        logic                last;
    } key_evt_t;

    // Scoreboard: typematic predictor plus the queue of key events still owed
    class key_event_board;
        cfg_t        cfg;
        logic        held [NKEYS];
        logic [31:0] deadline [NKEYS];
        key_evt_t    pending [$];
        int          errors;
        int          n_events;
        int          n_repeats;

        function new();
            cfg = '{RST_ENABLE, RST_TRIG_TH, RST_DIR_TH, RST_FIRST_DLY, RST_REPEAT};
            foreach (held[k])
            begin
                held[k]     = 1'b0;
                deadline[k] = '0;
            end
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_ENABLE:    cfg.enable     = val[0];
                REG_TRIG_TH:   cfg.trig_th    = val[14:0];
                REG_DIR_TH:    cfg.dir_th     = val[14:0];
                REG_FIRST_DLY: cfg.first_dly  = val[15:0];
                REG_REPEAT:    cfg.repeat_ivl = val[15:0];
                default:       ;
            endcase
        endfunction

        // Scan all keys in index order for one accepted request
        function void note_request(pad_req_t r);
            int          sx;
            int          sy;
            int          lt;
            int          rt;
            int          dth;
            int          first;
            logic        lvl;
            logic [31:0] age;
            key_evt_t    ev;
            sx    = $signed(r.sx);
            sy    = $signed(r.sy);
            lt    = $signed(r.lt);
            rt    = $signed(r.rt);
            dth   = int'(cfg.dir_th);
            first = pending.size();
            for (int k = 0; k < NKEYS; k++)
            begin
                lvl = 1'b0;
                if (r.req == REQ_POLL && cfg.enable)
                begin
                    if (k < NBUTTONS)
                        lvl = r.buttons[k];
                    else if (k == KEY_LTRIG)
                        lvl = (lt >= int'(cfg.trig_th));
                    else
                        lvl = (rt >= int'(cfg.trig_th));
                    // menu mode: stick past threshold also drives the d-pad
                    if (r.menu)
                    begin
                        if (k == KEY_UP)    lvl = lvl | (sy <= -dth);
                        if (k == KEY_DOWN)  lvl = lvl | (sy >= dth);
                        if (k == KEY_LEFT)  lvl = lvl | (sx <= -dth);
                        if (k == KEY_RIGHT) lvl = lvl | (sx >= dth);
                    end
                end
                age = r.now - deadline[k];
                ev  = '0;
                ev.key = KEY_BITS'(k);
                if (lvl != held[k])
                begin
                    held[k]     = lvl;
                    deadline[k] = r.now + cfg.first_dly;
                    ev.pressed  = lvl;
                    pending.push_back(ev);
                end
                else if (lvl && r.menu && r.req == REQ_POLL && !age[31])
                begin
                    deadline[k] = r.now + cfg.repeat_ivl;
                    ev.pressed  = 1'b1;
                    ev.rep      = 1'b1;
                    pending.push_back(ev);
                end
            end
            if (pending.size() > first)
            begin
                ev      = pending[pending.size() - 1];
                ev.last = 1'b1;
                pending[pending.size() - 1] = ev;
            end
        endfunction

        function void flag(string what, key_evt_t want, key_evt_t got);
            errors++;
            if (errors <= 10)
                $display("%0t: %s: exp key=%0d pressed=%0b repeat=%0b last=%0b,",
                         $time, what, want.key, want.pressed, want.rep, want.last,
                         " got key=%0d pressed=%0b repeat=%0b last=%0b",
                         got.key, got.pressed, got.rep, got.last);
        endfunction

        function void check_event(key_evt_t got);
            key_evt_t want;
            n_events++;
            if (got.rep)
                n_repeats++;
            if (pending.size() == 0)
            begin
                flag("event with nothing outstanding", '0, got);
                return;
            end
            want = pending.pop_front();
            if (want.key != got.key || want.pressed != got.pressed ||
                want.rep != got.rep || want.last != got.last)
                flag("event mismatch", want, got);
        endfunction
    endclass

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        push    = 1'b0;
    logic        full;
    pad_req_t    cur_req = '0;
    logic        empty;
    logic        pop     = 1'b0;
    logic [KEY_BITS-1:0] key_index;
    logic        pressed;
    logic        is_repeat;
    logic        last;

    key_event_board board;
    int send_idle  = 0;
    int recv_idle  = 0;
    int hold_left  = 0;
    int quiet      = 0;
    int n_requests = 0;
    int n_clears   = 0;

    // Random stream state: a slowly changing pad, like frame-to-frame polls
    logic [31:0] now_t;
    logic [13:0] btn;
    logic        menu;
    logic [15:0] st_x;
    logic [15:0] st_y;
    logic [15:0] trg_l;
    logic [15:0] trg_r;

    pad_key_auto_repeat u_top (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .push                (push),
        .full                (full),
        .req_type            (cur_req.req),
        .now_ms              (cur_req.now),
        .button_bits         (cur_req.buttons),
        .stick_x             (cur_req.sx),
        .stick_y             (cur_req.sy),
        .left_trigger_level  (cur_req.lt),
        .right_trigger_level (cur_req.rt),
        .menu_active         (cur_req.menu),
        .empty               (empty),
        .pop                 (pop),
        .key_index           (key_index),
        .pressed             (pressed),
        .is_repeat           (is_repeat),
        .last                (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Transfer monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            quiet++;
            if (push && !full)
            begin
                board.note_request(cur_req);
                n_requests++;
                if (cur_req.req == REQ_CLEAR)
                    n_clears++;
                quiet = 0;
            end
            if (pop && !empty)
            begin
                board.check_event('{key_index, pressed, is_repeat, last});
                quiet = 0;
            end
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Event receiver; a hold-off stalls it outright
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_idle);
        end
    end

    function automatic pad_req_t poll(logic [31:0] now, logic [13:0] buttons, int sx, int sy,
                                      int lt, int rt, logic menu_on);
        pad_req_t r;
        r.req     = REQ_POLL;
        r.now     = now;
        r.buttons = buttons;
        r.sx      = sx[15:0];
        r.sy      = sy[15:0];
        r.lt      = lt[15:0];
        r.rt      = rt[15:0];
        r.menu    = menu_on;
        return r;
    endfunction

    function automatic pad_req_t clear_req(logic [31:0] now);
        pad_req_t r;
        r      = poll(now, 14'h3FFF, 0, 0, 32767, 32767, 1'b1);
        r.req  = REQ_CLEAR;
        return r;
    endfunction

    function automatic logic [15:0] analog_value();
        case ($urandom_range(7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'(int'(board.cfg.dir_th) - $urandom_range(1));
            4:       return 16'(-int'(board.cfg.dir_th) + $urandom_range(1));
            5:       return 16'(int'(board.cfg.trig_th) - $urandom_range(1));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic pad_req_t random_req();
        pad_req_t r;
        if ($urandom_range(99) < 3)
            now_t = $urandom;
        else
            now_t = now_t + $urandom_range(0, 160);
        if ($urandom_range(99) < 30)
            btn[$urandom_range(13)] = ~btn[$urandom_range(13)];
        if ($urandom_range(99) < 4)
            btn = 14'($urandom);
        // menu mostly on, since repeats only happen there
        if ($urandom_range(99) < (menu ? 6 : 30))
            menu = ~menu;
        if ($urandom_range(99) < 20) st_x  = analog_value();
        if ($urandom_range(99) < 20) st_y  = analog_value();
        if ($urandom_range(99) < 20) trg_l = analog_value();
        if ($urandom_range(99) < 20) trg_r = analog_value();
        r.req     = ($urandom_range(99) < 5) ? REQ_CLEAR : REQ_POLL;
        r.now     = now_t;
        r.buttons = btn;
        r.sx      = st_x;
        r.sy      = st_y;
        r.lt      = trg_l;
        r.rt      = trg_r;
        r.menu    = menu;
        return r;
    endfunction

    task automatic send(input pad_req_t r);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        cur_req <= r;
        @(posedge clk);
        while (full)
            @(posedge clk);
    endtask

    // Stop offering and wait until every owed event has been seen and the block is quiet
    task automatic drain();
        push <= 1'b0;
        do
        begin
            while (board.pending.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
        while (board.pending.size() != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        board.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config();
        int pick;
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_TRIG_TH, ($urandom_range(9) == 0) ? 32'h7FFF : $urandom_range(0, 20000));
        write_reg(REG_DIR_TH, ($urandom_range(9) == 0) ? 32'd0 : $urandom_range(8000, 32767));
        pick = $urandom_range(9);
        write_reg(REG_FIRST_DLY, (pick == 0) ? 32'd0 :
                                 (pick == 9) ? 32'hFFFF : $urandom_range(20, 600));
        pick = $urandom_range(9);
        write_reg(REG_REPEAT, (pick == 0) ? 32'd0 :
                              (pick == 9) ? 32'hFFFF : $urandom_range(10, 200));
    endtask

    task automatic random_phase(input int s_idle, input int r_idle, input logic stress);
        send_idle = s_idle;
        recv_idle = r_idle;
        random_config();
        if (stress)
            hold_left = HOLD_CYCLES;
        for (int n = 0; n < PHASE_ITEMS; n++)
            send(random_req());
        drain();
    endtask

    initial
    begin
        logic [31:0] t0;
        logic [31:0] t1;
        board     = new();
        t0        = 32'h0000_1000;
        t1        = 32'hFFFF_FF00;
        send_idle = 20;
        recv_idle = 20;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Defaults: full press/release sweep, first repeat at the deadline, stick
        // directions, clear with and without held keys, trigger threshold edges
        send(poll(t0,        14'h3FFF, 0, 0, 32767, 32767, 1'b0));
        send(poll(t0 + 10,   14'h0000, 0, 0, -32768, -32768, 1'b0));
        send(poll(t0 + 20,   14'h0001, 0, 0, 0, 0, 1'b1));
        send(poll(t0 + 519,  14'h0001, 0, 0, 0, 0, 1'b1));
        send(poll(t0 + 520,  14'h0001, 0, 0, 0, 0, 1'b1));
        send(poll(t0 + 620,  14'h0001, -32768, 32767, 0, 0, 1'b1));
        send(poll(t0 + 630,  14'h0001, 32767, -32768, 0, 0, 1'b1));
        send(poll(t0 + 640,  14'h0001, 32767, -32768, 0, 0, 1'b0));
        send(clear_req(t0 + 650));
        send(clear_req(t0 + 660));
        send(poll(t0 + 700,  14'h0000, 0, 0, 6554, 6553, 1'b0));
        send(poll(t0 + 710,  14'h0000, 0, 0, 6553, 6554, 1'b0));
        send(poll(t0 + 800,  14'h0000, -22938, 22937, -1, 0, 1'b1));
        send(poll(t0 + 810,  14'h0000, 22938, -22937, -1, 0, 1'b1));
        drain();

        // Disabled: everything reads released, a clear still works
        write_reg(REG_ENABLE, 32'd0);
        send(poll(t0 + 900,  14'h3FFF, -32768, -32768, 32767, 32767, 1'b1));
        send(clear_req(t0 + 910));
        drain();

        // Zero thresholds and zero delays: centred stick presses all four, repeats every poll
        write_reg(REG_ENABLE, 32'd1);
        write_reg(REG_DIR_TH, 32'd0);
        write_reg(REG_TRIG_TH, 32'd0);
        write_reg(REG_FIRST_DLY, 32'd0);
        write_reg(REG_REPEAT, 32'd0);
        send(poll(t0 + 1000, 14'h0000, 0, 0, 0, -1, 1'b1));
        send(poll(t0 + 1000, 14'h0000, 0, 0, 0, -1, 1'b1));
        drain();

        // Top thresholds and delays, with time wrapping through zero
        write_reg(REG_DIR_TH, 32'h7FFF);
        write_reg(REG_TRIG_TH, 32'h7FFF);
        write_reg(REG_FIRST_DLY, 32'hFFFF);
        write_reg(REG_REPEAT, 32'hFFFF);
        send(poll(t1,           14'h0000, -32768, 32767, 32767, 32766, 1'b1));
        send(poll(t1 + 32'hFFFF, 14'h2AAA, -32768, 32767, 32767, 32766, 1'b1));
        send(poll(t1 + 32'h1FFFE, 14'h1555, -32767, 32766, 32766, 32767, 1'b1));
        drain();

        // Random frame streams
        now_t = $urandom;
        btn   = '0;
        menu  = 1'b1;
        st_x  = '0;
        st_y  = '0;
        trg_l = '0;
        trg_r = '0;
        random_phase(35, 83, 1'b0);
        random_phase(83, 35, 1'b0);
        random_phase(0, 0, 1'b1);

        $display("ran %0d requests (%0d clears) over several register settings", n_requests,
                 n_clears);
        $display("checked %0d key events, %0d auto-repeats, %0d failures", board.n_events,
                 board.n_repeats, board.errors);
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
